// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL. Every check samples on the rising
// clock edge and is switched off while the asynchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled edge.
`define CED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define CED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ced_pkg.sv
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types, constants and helpers of the capped edit distance block.
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int unsigned MaxLenDefault = 32;
  localparam int unsigned CapW          = 6;
  localparam int unsigned CharW         = 8;
  localparam int unsigned DistW         = 6;
  localparam logic [CapW-1:0] CapReset  = 6'd3;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FEED   = 2'd1,
    OP_FINISH = 2'd2
  } op_e;

  typedef enum logic {
    ST_RUN   = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  // Fold upper-case ASCII letters to lower case; other bytes pass unchanged.
  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: rtl/ced_cell.sv
// ----------------------------------------------------------------------------
// ced_cell
// One column of the distance row: holds a reference character and the row
// value at its position, and updates it as each second-string character
// passes by on the wavefront from its left neighbor.
// ----------------------------------------------------------------------------
module ced_cell import ced_pkg::*; #(
  parameter int unsigned VW  = 6,
  parameter int unsigned IDX = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             wr_i,
  input  logic [CharW-1:0] wr_char_i,
  input  logic [CapW-1:0]  cap_i,
  input  logic             valid_i,
  input  logic [CharW-1:0] ch_i,
  input  logic [VW-1:0]    left_i,
  input  logic [VW-1:0]    diag_i,
  output logic             valid_o,
  output logic [CharW-1:0] ch_o,
  output logic [VW-1:0]    left_o,
  output logic [VW-1:0]    diag_o,
  output logic [VW-1:0]    value_o
);

  localparam int unsigned SW = ((VW > CapW) ? VW : CapW) + 1;

  logic [CharW-1:0] ref_q;
  logic [VW-1:0]    val_q, val_d;
  logic             valid_q;
  logic [CharW-1:0] ch_q;
  logic [VW-1:0]    left_q, diag_q;

  logic [VW-1:0] min_v;
  logic [SW-1:0] cand, limit;

  always_comb begin
    min_v = val_q;
    if (left_i < min_v) begin
      min_v = left_i;
    end
    if (diag_i < min_v) begin
      min_v = diag_i;
    end
    cand  = (ref_q == ch_i) ? SW'(diag_i) : SW'(min_v) + SW'(1);
    limit = SW'(cap_i) + SW'(1);
    // Anything above the cap reads as cap plus one, cut to VW bits.
    val_d = (cand > SW'(cap_i)) ? VW'(limit) : VW'(cand);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ref_q <= wr_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q   <= VW'(IDX);
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
      if (clear_i) begin
        val_q <= VW'(IDX);
      end else if (valid_i) begin
        val_q <= val_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      ch_q   <= ch_i;
      left_q <= val_d;
      diag_q <= val_q;
    end
  end

  assign valid_o = valid_q;
  assign ch_o    = ch_q;
  assign left_o  = left_q;
  assign diag_o  = diag_q;
  assign value_o = val_q;

endmodule

// File: rtl/capped_edit_distance.sv
// Append and feed transactions are taken one per cycle while no finish is
// draining; a fed character walks down the cell chain one cell per cycle
// behind the previous one. A finish transaction holds input off until the
// chain has drained and the output is free; then the result is registered.
// Reset (asynchronous, active low) empties both strings and sets the cap to 3.
// ----------------------------------------------------------------------------
// capped_edit_distance
// Case-insensitive Levenshtein distance between a stored reference string
// and a streamed second string, computed by a systolic row of cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module capped_edit_distance import ced_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CapW-1:0]  cfg_data_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // [7:0] ch
  input  logic [1:0]       s_axis_tuser_i,   // [1:0] op
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o    // [5:0] distance, [6] overflow
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned VW = $clog2(MAX_LEN + 2);
  localparam int unsigned FW = (LW > VW) ? LW : VW;

  state_e state_q, state_d;

  logic [CapW-1:0] cap_q;
  logic [LW-1:0]   ref_len_q, second_len_q;
  logic            ovf_q;

  logic             out_valid_q;
  logic [DistW-1:0] out_dist_q;
  logic             out_ovf_q;

  logic             inj_valid_q;
  logic [CharW-1:0] inj_ch_q;
  logic [VW-1:0]    inj_left_q, inj_diag_q;

  // Token chain: position 0 is the injection register, k is the output of cell k-1.
  logic             tok_valid [MAX_LEN+1];
  logic [CharW-1:0] tok_ch    [MAX_LEN+1];
  logic [VW-1:0]    tok_left  [MAX_LEN+1];
  logic [VW-1:0]    tok_diag  [MAX_LEN+1];
  logic [VW-1:0]    cell_val  [MAX_LEN];
  logic [MAX_LEN:0] busy_vec;

  logic             in_acc;
  op_e              op;
  logic [CharW-1:0] ch_fold;
  logic             do_append, do_feed, chain_busy, load_out;
  logic [VW-1:0]    sel_val;
  logic [FW-1:0]    dist_full;

  assign op        = op_e'(s_axis_tuser_i);
  assign ch_fold   = fold_case(s_axis_tdata_i);
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign do_append = in_acc && (op == OP_APPEND) && (second_len_q == '0)
                     && (ref_len_q != LW'(MAX_LEN));
  assign do_feed   = in_acc && (op == OP_FEED) && (second_len_q != LW'(MAX_LEN));

  assign tok_valid[0] = inj_valid_q;
  assign tok_ch[0]    = inj_ch_q;
  assign tok_left[0]  = inj_left_q;
  assign tok_diag[0]  = inj_diag_q;

  always_comb begin
    for (int k = 0; k <= MAX_LEN; k++) begin
      busy_vec[k] = tok_valid[k];
    end
  end
  assign chain_busy = |busy_vec;
  assign load_out   = (state_q == ST_DRAIN) && !chain_busy
                      && (!out_valid_q || m_axis_tready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_acc && op == OP_FINISH) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (load_out) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // State outputs.
  always_comb begin
    unique case (state_q)
      ST_RUN:   s_axis_tready_o = 1'b1;
      ST_DRAIN: s_axis_tready_o = 1'b0;
      default:  s_axis_tready_o = 1'b0;
    endcase
  end

  // Pick the row value at the end of the reference; an empty string gives the other's length.
  always_comb begin
    sel_val = '0;
    for (int k = 0; k < MAX_LEN; k++) begin
      if (ref_len_q == LW'(k + 1)) begin
        sel_val = cell_val[k];
      end
    end
    if (ref_len_q == '0) begin
      dist_full = FW'(second_len_q);
    end else if (second_len_q == '0) begin
      dist_full = FW'(ref_len_q);
    end else begin
      dist_full = FW'(sel_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      cap_q        <= CapReset;
      ref_len_q    <= '0;
      second_len_q <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      inj_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      inj_valid_q <= do_feed;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (in_acc) begin
        unique case (op)
          OP_APPEND: begin
            if (second_len_q == '0) begin
              if (ref_len_q == LW'(MAX_LEN)) begin
                ovf_q <= 1'b1;
              end else begin
                ref_len_q <= ref_len_q + LW'(1);
              end
            end
          end
          OP_FEED: begin
            if (second_len_q == LW'(MAX_LEN)) begin
              ovf_q <= 1'b1;
            end else begin
              second_len_q <= second_len_q + LW'(1);
            end
          end
          default: ;
        endcase
      end
      if (load_out) begin
        ref_len_q    <= '0;
        second_len_q <= '0;
        ovf_q        <= 1'b0;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_feed) begin
      inj_ch_q   <= ch_fold;
      inj_left_q <= VW'(second_len_q) + VW'(1);
      inj_diag_q <= VW'(second_len_q);
    end
    if (load_out) begin
      out_dist_q <= DistW'(dist_full);
      out_ovf_q  <= ovf_q;
    end
  end

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    ced_cell #(
      .VW  (VW),
      .IDX (g + 1)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clear_i   (load_out),
      .wr_i      (do_append && (ref_len_q == LW'(g))),
      .wr_char_i (ch_fold),
      .cap_i     (cap_q),
      .valid_i   (tok_valid[g]),
      .ch_i      (tok_ch[g]),
      .left_i    (tok_left[g]),
      .diag_i    (tok_diag[g]),
      .valid_o   (tok_valid[g+1]),
      .ch_o      (tok_ch[g+1]),
      .left_o    (tok_left[g+1]),
      .diag_o    (tok_diag[g+1]),
      .value_o   (cell_val[g])
    );
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_ovf_q, out_dist_q};

  `CED_ASSERT(a_ref_len_bound, ref_len_q <= LW'(MAX_LEN), "reference length past MAX_LEN")
  `CED_ASSERT_NEXT(a_result_after_drain, !out_valid_q && !$past(out_valid_q) && (state_q == ST_DRAIN) && chain_busy, !out_valid_q, "result issued before the chain drained")
  `CED_ASSERT_NEXT(a_append_locked, in_acc && op == OP_APPEND && second_len_q != '0, $stable(ref_len_q), "reference grew after second string began")
  `CED_ASSERT_NEXT(a_clear_on_emit, load_out, ref_len_q == '0 && second_len_q == '0 && !ovf_q, "strings not cleared on finish")

endmodule

// File: verif/tb_capped_edit_distance.sv
// ----------------------------------------------------------------------------
// tb_capped_edit_distance
// Self-checking bench for the capped edit distance block. A behavioral copy
// of the distance row runs beside the block, and every finish transaction
// queues the distance and overflow mark it should produce. Directed strings
// cover case folding, byte extremes, empty strings, ignored items, capping
// and string overflow. Random words then run under several cap settings and
// under several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_capped_edit_distance;
  import ced_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxLen     = MaxLenDefault;
  localparam int unsigned SettleCyc  = MaxLen + 8;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0]  OpUnused   = 2'd3;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             overflow;
  } distance_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CapW-1:0]  cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_char = '0;
  logic [1:0]       in_op = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_data;

  // Shadow copy of the block state.
  logic [CapW-1:0]  model_cap;
  logic [7:0]       model_ref [MaxLen];
  int unsigned      model_ref_len;
  int unsigned      model_second_len;
  logic [6:0]       model_row [0:MaxLen];
  logic             model_overflow;

  distance_result_t expected_distances [$];
  int unsigned      error_count = 0;
  int unsigned      counted_items = 0;
  int unsigned      cycle_count = 0;
  int unsigned      sender_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;

  capped_edit_distance uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_char),    // [7:0] ch
    .s_axis_tuser_i  (in_op),      // [1:0] op
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)    // [5:0] distance, [6] overflow
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_capped_edit_distance: done, errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input int unsigned exp_val,
                                 input int unsigned got_val);
    $display("MISMATCH at cycle %0d: %s expected %0d got %0d",
             cycle_count, what, exp_val, got_val);
    error_count++;
  endtask

  // Result checker: every result transaction is matched against the oldest
  // queued expectation.
  always @(posedge clk_i) begin
    distance_result_t exp_res;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_distances.size() == 0) begin
        report_mismatch("unexpected result, distance", 0, out_data[5:0]);
      end else begin
        exp_res = expected_distances.pop_front();
        if (out_data[5:0] != exp_res.distance)
          report_mismatch("distance", exp_res.distance, out_data[5:0]);
        if (out_data[6] != exp_res.overflow)
          report_mismatch("overflow", exp_res.overflow, out_data[6]);
        if (out_data[7] != 1'b0)
          report_mismatch("padding bit", 0, out_data[7]);
      end
    end
  end

  function automatic logic [7:0] to_lower(input logic [7:0] raw);
    logic [7:0] c;
    c = raw;
    if (c inside {[8'h41:8'h5A]}) c = c | 8'h20;
    return c;
  endfunction

  function automatic void clear_model_strings();
    model_ref_len    = 0;
    model_second_len = 0;
    model_overflow   = 1'b0;
    for (int i = 0; i <= MaxLen; i++) model_row[i] = 7'(i);
  endfunction

  // One column of the distance table; computed cells saturate at cap + 1.
  function automatic void advance_distance_row(input logic [7:0] c);
    logic [6:0] prev [0:MaxLen];
    logic [6:0] best;
    logic [6:0] next_val;
    logic [6:0] ceiling;
    prev    = model_row;
    ceiling = {1'b0, model_cap} + 7'd1;
    model_row[0] = prev[0] + 7'd1;
    for (int i = 1; i <= model_ref_len; i++) begin
      if (model_ref[i-1] == c) begin
        next_val = prev[i-1];
      end else begin
        best = prev[i];
        if (model_row[i-1] < best) best = model_row[i-1];
        if (prev[i-1] < best) best = prev[i-1];
        next_val = best + 7'd1;
      end
      if (next_val > {1'b0, model_cap}) next_val = ceiling;
      model_row[i] = next_val;
    end
  endfunction

  // Applies one accepted transaction to the shadow state and queues the
  // result a finish should produce.
  function automatic void predict_distance(input logic [1:0] op, input logic [7:0] raw);
    distance_result_t res;
    logic [7:0]       c;
    int unsigned      d;
    c = to_lower(raw);
    case (op)
      OP_APPEND: begin
        if (model_second_len == 0) begin
          counted_items++;
          if (model_ref_len >= MaxLen) begin
            model_overflow = 1'b1;
          end else begin
            model_ref[model_ref_len] = c;
            model_ref_len++;
          end
        end
      end
      OP_FEED: begin
        counted_items++;
        if (model_second_len >= MaxLen) begin
          model_overflow = 1'b1;
        end else begin
          advance_distance_row(c);
          model_second_len++;
        end
      end
      OP_FINISH: begin
        counted_items++;
        if (model_ref_len == 0) d = model_second_len;
        else if (model_second_len == 0) d = model_ref_len;
        else d = model_row[model_ref_len];
        res.distance = DistW'(d);
        res.overflow = model_overflow;
        expected_distances = {expected_distances, res};
        clear_model_strings();
      end
      default: begin
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_char  <= ch;
    do @(posedge clk_i); while (!in_ready);
    predict_distance(op, ch);
    @(negedge clk_i);
  endtask

  task automatic send_text(input logic [1:0] op, input string text);
    for (int i = 0; i < text.len(); i++) send_item(op, text[i]);
  endtask

  // Drops valid and waits for every queued result; with settle set it also
  // lets the cell chain empty out so the cap may be changed safely.
  task automatic drain_results(input bit settle);
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (expected_distances.size() != 0) @(negedge clk_i);
    if (settle) repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_cap(input logic [CapW-1:0] value);
    drain_results(1'b1);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    model_cap = value;
    @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    sender_idle_pct = send_pct;
    recv_stall_pct  = stall_pct;
  endtask

  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 85) return $urandom_range(8);
    if (roll < 95) return $urandom_range(MaxLen);
    return $urandom_range(MaxLen + 2, MaxLen - 2);
  endfunction

  // A small mixed-case alphabet makes matches common; full bytes cover
  // every character bit.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    if ($urandom_range(99) < 70) begin
      c = 8'h61 + 8'($urandom_range(3));
      if ($urandom_range(1)) c = c & 8'hDF;
    end else begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  // Mostly well-formed words; some carry stray items or lack the finish.
  task automatic send_random_word();
    int unsigned ref_n;
    int unsigned sec_n;
    ref_n = pick_length();
    sec_n = pick_length();
    for (int i = 0; i < ref_n; i++) send_item(OP_APPEND, pick_char());
    for (int i = 0; i < sec_n; i++) begin
      send_item(OP_FEED, pick_char());
      if ($urandom_range(99) < 4) send_item(OP_APPEND, pick_char());
      if ($urandom_range(99) < 3) send_item(OpUnused, 8'($urandom_range(255)));
    end
    if ($urandom_range(99) >= 5) send_item(OP_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic send_random_words(input int unsigned item_goal);
    int unsigned stop_at;
    stop_at = counted_items + item_goal;
    while (counted_items < stop_at) send_random_word();
    send_item(OP_FINISH, 8'h00);
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_item(OP_FINISH, 8'h00);
    // Only a reference: its length comes back beyond the cap.
    send_text(OP_APPEND, "ABCDE");
    send_item(OP_FINISH, 8'hFF);
    // Only a second string.
    send_item(OP_FEED, "x");
    send_item(OP_FINISH, 8'h00);
    // Folding applies to letters only; the late append and op 3 are ignored.
    send_item(OP_APPEND, "Z");
    send_item(OP_APPEND, 8'hFF);
    send_item(OP_APPEND, "[");
    send_item(OP_FEED, "z");
    send_item(OP_APPEND, "q");
    send_item(OP_FEED, 8'hFF);
    send_item(OP_FEED, "{");
    send_item(OpUnused, 8'hAA);
    send_item(OP_FINISH, 8'h00);
    // Nothing matches: the distance saturates at cap plus one.
    send_text(OP_APPEND, "abcd");
    send_text(OP_FEED, "WXYZ");
    send_item(OP_FINISH, 8'h00);
  endtask

  task automatic test_string_overflow();
    set_idling(15, 15);
    // Both strings exactly full, then one character beyond on each side.
    for (int i = 0; i < MaxLen; i++) send_item(OP_APPEND, pick_char());
    for (int i = 0; i < MaxLen; i++) send_item(OP_FEED, pick_char());
    send_item(OP_FINISH, 8'h00);
    for (int i = 0; i <= MaxLen; i++) send_item(OP_APPEND, pick_char());
    for (int i = 0; i <= MaxLen; i++) send_item(OP_FEED, pick_char());
    send_item(OP_FINISH, 8'h00);
    for (int i = 0; i <= MaxLen; i++) send_item(OP_FEED, 8'h00);
    send_item(OP_FINISH, 8'h00);
  endtask

  task automatic test_cap_settings();
    logic [CapW-1:0] caps [6];
    caps = '{6'd0, 6'd1, 6'd32, 6'd63, CapW'($urandom_range(32)), 6'd3};
    foreach (caps[k]) begin
      write_cap(caps[k]);
      case (k % 4)
        0: set_idling(0, 0);
        1: set_idling(66, 0);
        2: set_idling(0, 66);
        default: set_idling(15, 15);
      endcase
      send_random_words(100);
    end
  endtask

  task automatic test_idle_patterns();
    set_idling(0, 0);
    send_random_words(150);
    set_idling(66, 0);
    send_random_words(150);
    // The sender holds off until the output side has caught up.
    drain_results(1'b0);
    set_idling(0, 66);
    send_random_words(150);
    set_idling(15, 15);
    send_random_words(150);
  endtask

  initial begin
    model_cap = CapReset;
    clear_model_strings();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_string_overflow();
    test_cap_settings();
    test_idle_patterns();

    drain_results(1'b1);
    if (expected_distances.size() != 0)
      report_mismatch("results left over", 0, expected_distances.size());
    if (error_count == 0) begin
      $display("tb_capped_edit_distance: done, clean");
    end else begin
      $display("tb_capped_edit_distance: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ced_pkg.sv
rtl/ced_cell.sv
rtl/capped_edit_distance.sv
verif/tb_capped_edit_distance.sv
